// ----- sv/encoder_pulse_rate_averager_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the encoder pulse rate averager.
// Every macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ENCODER_PULSE_RATE_AVERAGER_MACROS_SVH
`define ENCODER_PULSE_RATE_AVERAGER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define EPRA_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define EPRA_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An implication checked in the next cycle.
`define EPRA_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/epra_pkg.sv -----
// ----------------------------------------------------------------------------
// epra_pkg
// Types and constants shared by the encoder pulse rate averager modules.
// ----------------------------------------------------------------------------
`default_nettype none

package epra_pkg;

  // Default number of intervals in the averaging window.
  localparam int WINDOW_DEF = 10;

  // Width of one stored interval (the low 31 bits of a non-negative 32-bit difference).
  localparam int INTERVAL_W = 31;

  // Reset value of the pulses-per-revolution register.
  localparam logic [7:0] PPR_RESET = 8'd15;

  // 1e6 microseconds per second times 2^16 for the Q16.16 result.
  localparam logic [63:0] RATE_SCALE = 64'd65536000000;

  // Saturated speed.
  localparam logic [31:0] SPEED_MAX = 32'hFFFF_FFFF;

  // Request kinds.
  localparam logic MODE_EDGE    = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;

  // One input request.
  typedef struct packed {
    logic        mode;
    logic [31:0] edge_time_us;
  } in_t;

  // One result.
  typedef struct packed {
    logic [31:0] revs_per_sec_q16;
    logic [3:0]  samples_held;
    logic        saturated;
  } out_t;

endpackage

`default_nettype wire

// ----- sv/epra_ram.sv -----
// ----------------------------------------------------------------------------
// epra_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module epra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/epra_front.sv -----
// ----------------------------------------------------------------------------
// epra_front
// Accepts requests, keeps the interval window and the running sum, and hands
// the window count and sum of every request to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "encoder_pulse_rate_averager_macros.svh"

module epra_front #(
  parameter int WINDOW = 10,
  parameter int CNT_W  = 4,
  parameter int SUM_W  = 35
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire epra_pkg::in_t     in_data,
  output logic                   full,
  input  wire logic              job_full,
  output logic                   job_push,
  output logic       [CNT_W-1:0] job_held,
  output logic       [SUM_W-1:0] job_sum
);

  import epra_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  state_t             state_r, state_nxt;
  in_t                item_r;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [31:0]        last_r, last_nxt;
  logic               accept;
  logic [31:0]        diff;
  logic               ring_we;
  logic [INTERVAL_W-1:0] oldest;

  // A request is taken only when idle and the queue has room for its job.
  assign full   = (state_r != S_IDLE) || job_full;
  assign accept = push && !full;
  assign diff   = item_r.edge_time_us - last_r;

  // Interval ring; the oldest entry is read at the slot about to be written.
  epra_ram #(
    .WIDTH (INTERVAL_W),
    .DEPTH (WINDOW),
    .AW    (SLOT_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot_r),
    .wdata (diff[INTERVAL_W-1:0]),
    .re    (accept),
    .raddr (slot_r),
    .rdata (oldest)
  );

  // Window update in the cycle after acceptance.
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    held_nxt  = held_r;
    sum_nxt   = sum_r;
    last_nxt  = last_r;
    ring_we   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = S_IDLE;
        if (item_r.mode == MODE_TIMEOUT) begin
          slot_nxt = '0;
          held_nxt = '0;
          sum_nxt  = '0;
        end else if (!diff[31]) begin
          ring_we  = 1'b1;
          last_nxt = item_r.edge_time_us;
          if (held_r == CNT_W'(WINDOW)) begin
            sum_nxt = sum_r - SUM_W'(oldest) + SUM_W'(diff[INTERVAL_W-1:0]);
          end else begin
            held_nxt = held_r + 1'b1;
            sum_nxt  = sum_r + SUM_W'(diff[INTERVAL_W-1:0]);
          end
          slot_nxt = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The job carries the window as it stands after this request.
  assign job_push = (state_r == S_UPD);
  assign job_held = held_nxt;
  assign job_sum  = sum_nxt;

  // State and window registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= '0;
      held_r  <= '0;
      sum_r   <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      held_r  <= held_nxt;
      sum_r   <= sum_nxt;
      last_r  <= last_nxt;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  `EPRA_ALWAYS(a_held_bound, held_r <= CNT_W'(WINDOW), "window count above its size")
  `EPRA_ALWAYS(a_slot_bound, slot_r <= SLOT_W'(WINDOW - 1), "write slot out of range")
  `EPRA_IMPLIES(a_empty_sum, held_r == '0, sum_r == '0, "empty window with nonzero sum")

endmodule

`default_nettype wire

// ----- sv/epra_queue.sv -----
// ----------------------------------------------------------------------------
// epra_queue
// Two-entry job queue between the window front end and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

`include "encoder_pulse_rate_averager_macros.svh"

module epra_queue #(
  parameter int WIDTH = 39
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  `EPRA_IMPLIES(a_no_lost_job, push, !full, "job pushed into a full queue")
  `EPRA_ALWAYS(a_count_bound, count_r != 2'd3, "queue count out of range")
  `EPRA_IMPLIES(a_ptr_match, empty || full, wr_ptr_r == rd_ptr_r, "queue pointers disagree")

endmodule

`default_nettype wire

// ----- sv/epra_back.sv -----
// ----------------------------------------------------------------------------
// epra_back
// Takes one job at a time, forms the scaled count and the denominator, runs a
// restoring divide one quotient bit per cycle and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "encoder_pulse_rate_averager_macros.svh"

module epra_back #(
  parameter int WINDOW = 10,
  parameter int CNT_W  = 4,
  parameter int SUM_W  = 35
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_empty,
  input  wire logic  [CNT_W-1:0] job_held,
  input  wire logic  [SUM_W-1:0] job_sum,
  output logic                   job_pop,
  input  wire logic        [7:0] ppr,
  output epra_pkg::out_t         out_data,
  output logic                   empty,
  input  wire logic              pop
);

  import epra_pkg::*;

  localparam logic [63:0] NUM_MAX = RATE_SCALE * WINDOW;
  localparam int NUM_W   = $clog2(NUM_MAX + 64'd1);
  localparam int DEN_W   = SUM_W + 8;
  localparam int STEP_W  = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  out_t              out_r, out_nxt;
  logic              valid_r, valid_nxt;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              rem_ge;
  logic              skip_div;
  logic              load_out;

  // One restoring divide step.
  assign rem_sh   = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, den_r});
  assign rem_sub  = rem_sh - {1'b0, den_r};
  assign skip_div = (held_r == '0) || (den_r == '0);
  assign load_out = !valid_r || pop;

  assign job_pop  = (state_r == S_IDLE) && !job_empty;
  assign out_data = out_r;
  assign empty    = !valid_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    sum_nxt   = sum_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    out_nxt   = out_r;
    valid_nxt = valid_r && !pop;
    case (state_r)
      S_IDLE: begin
        if (!job_empty) begin
          held_nxt  = job_held;
          sum_nxt   = job_sum;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        den_nxt   = DEN_W'(sum_r) * DEN_W'(ppr);
        quo_nxt   = NUM_W'(RATE_SCALE * 64'(held_r));
        rem_nxt   = '0;
        step_nxt  = STEP_W'(NUM_W);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (skip_div || step_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          rem_nxt  = rem_ge ? rem_sub : rem_sh;
          quo_nxt  = {quo_r[NUM_W-2:0], rem_ge};
          step_nxt = step_r - 1'b1;
        end
      end
      S_DONE: begin
        if (load_out) begin
          valid_nxt = 1'b1;
          out_nxt.samples_held = 4'(held_r);
          if (held_r == '0) begin
            out_nxt.revs_per_sec_q16 = '0;
            out_nxt.saturated        = 1'b0;
          end else if (den_r == '0 || quo_r[NUM_W-1:32] != '0) begin
            out_nxt.revs_per_sec_q16 = SPEED_MAX;
            out_nxt.saturated        = 1'b1;
          end else begin
            out_nxt.revs_per_sec_q16 = quo_r[31:0];
            out_nxt.saturated        = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, datapath and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    held_r <= held_nxt;
    sum_r  <= sum_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    out_r  <= out_nxt;
  end

  `EPRA_IMPLIES(a_rem_below_den, state_r == S_DIV && !skip_div,
                rem_r < {1'b0, den_r}, "divide remainder not below divisor")
  `EPRA_NEXT(a_result_held, valid_r && !pop, valid_r && $stable(out_r),
             "waiting result changed before it was taken")

endmodule

`default_nettype wire

// ----- sv/encoder_pulse_rate_averager.sv -----
// ----------------------------------------------------------------------------
// encoder_pulse_rate_averager
// Moving-average period tachometer: speed in Q16.16 revolutions per second.
// ----------------------------------------------------------------------------
// Requests enter through push/full: each is an encoder edge with its
// microsecond timestamp, or a timeout that empties the averaging window.
// Every request yields exactly one result, read through empty/pop in order:
// speed, number of intervals in the window, and a saturation flag.
// The front end takes a request and updates the window in the next cycle
// (one read of the interval ring RAM), and takes no new request until that
// update is done. The back end divides one quotient bit per cycle and takes
// one job at a time, so its divide sets the sustained rate.
// A two-entry queue sits between the two halves and the result register
// lets the next request be divided while a result waits to be popped.
// When the receiver stalls, the back end holds its finished result, the
// queue fills and full rises; nothing is lost.
// Reset clears the window, last edge time, job queue and result register and
// loads the pulses-per-revolution register with 15. cfg_we writes that
// register. Use it only while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_pulse_rate_averager #(
  parameter int WINDOW = epra_pkg::WINDOW_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire epra_pkg::in_t  in_data,
  output logic                full,
  output logic                empty,
  input  wire logic           pop,
  output epra_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic     [7:0] cfg_wdata
);

  import epra_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = INTERVAL_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
  localparam int JOB_W = CNT_W + SUM_W;

  logic [7:0]       ppr_r;
  logic             job_push;
  logic             job_full;
  logic             job_pop;
  logic             job_empty;
  logic [CNT_W-1:0] fe_held;
  logic [SUM_W-1:0] fe_sum;
  logic [JOB_W-1:0] job_rdata;

  // Pulses-per-revolution register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r <= PPR_RESET;
    end else if (cfg_we) begin
      ppr_r <= cfg_wdata;
    end
  end

  // Window front end.
  epra_front #(
    .WINDOW (WINDOW),
    .CNT_W  (CNT_W),
    .SUM_W  (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .job_full (job_full),
    .job_push (job_push),
    .job_held (fe_held),
    .job_sum  (fe_sum)
  );

  // Job queue.
  epra_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata ({fe_held, fe_sum}),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty)
  );

  // Divider back end.
  epra_back #(
    .WINDOW (WINDOW),
    .CNT_W  (CNT_W),
    .SUM_W  (SUM_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_held  (job_rdata[JOB_W-1:SUM_W]),
    .job_sum   (job_rdata[SUM_W-1:0]),
    .job_pop   (job_pop),
    .ppr       (ppr_r),
    .out_data  (out_data),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire
